// File: hdl/i2crf_pkg.sv
// Shared types, codes and constants of the I2C target register block.
package i2crf_pkg;

    localparam int OFFS_W = 6;
    localparam int CFG_INDEX_W = 3;

    // Input commands.
    localparam logic [2:0] CMD_BUS_WRITE = 3'd0;
    localparam logic [2:0] CMD_BUS_READ  = 3'd1;
    localparam logic [2:0] CMD_BUS_STOP  = 3'd2;
    localparam logic [2:0] CMD_STAGE     = 3'd3;
    localparam logic [2:0] CMD_COMMIT    = 3'd4;
    localparam logic [2:0] CMD_NAME      = 3'd5;
    localparam logic [2:0] CMD_TAKE      = 3'd6;

    // Result kinds.
    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_VERSION     = 3'd0;
    localparam logic [2:0] REG_FILTER_BASE = 3'd1;
    localparam logic [2:0] REG_CODE_STATUS = 3'd2;
    localparam logic [2:0] REG_CODE_DEVCNT = 3'd3;
    localparam logic [2:0] REG_CODE_EVENT  = 3'd4;
    localparam logic [2:0] REG_CODE_NAME   = 3'd5;
    localparam logic [2:0] REG_CODE_SWRITE = 3'd6;

    // Configuration reset values.
    localparam logic [3:0] RST_VERSION     = 4'd1;
    localparam logic [7:0] RST_FILTER_BASE = 8'd224;
    localparam logic [7:0] RST_CODE_STATUS = 8'd0;
    localparam logic [7:0] RST_CODE_DEVCNT = 8'd1;
    localparam logic [7:0] RST_CODE_EVENT  = 8'd2;
    localparam logic [7:0] RST_CODE_NAME   = 8'd3;
    localparam logic [7:0] RST_CODE_SWRITE = 8'd4;

    localparam logic [7:0] BYTE_UNKNOWN = 8'hFF;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [8:0] FILTER_SPAN  = 9'd16;
    localparam int DEFAULT_NAME_LEN = 10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TAKE_READ,
        ST_TAKE_LOAD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic take_start;
        logic take_read;
        logic take_load;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic take_full;
        logic take_last;
    } t_dp_stat;

    // Default device name text "I2C Target", zero padded.
    function automatic logic [7:0] default_name_byte(input logic [OFFS_W-1:0] pos);
        logic [7:0] b;
        case (pos)
            6'd0: b = 8'h49;
            6'd1: b = 8'h32;
            6'd2: b = 8'h43;
            6'd3: b = 8'h20;
            6'd4: b = 8'h54;
            6'd5: b = 8'h61;
            6'd6: b = 8'h72;
            6'd7: b = 8'h67;
            6'd8: b = 8'h65;
            6'd9: b = 8'h74;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: hdl/i2crf_in_if.sv
// Input command channel of the I2C target register block.
interface i2crf_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] data;
    logic [5:0] index;
    logic [7:0] source_addr;

    modport source (output valid, output command, output data, output index,
                    output source_addr, input ready);
    modport sink (input valid, input command, input data, input index,
                  input source_addr, output ready);
endinterface

// File: hdl/i2crf_out_if.sv
// Result channel of the I2C target register block.
interface i2crf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_data;
    logic       last;

    modport source (output valid, output kind, output out_data, output last,
                    input ready);
    modport sink (input valid, input kind, input out_data, input last,
                  output ready);
endinterface

// File: hdl/i2crf_cfg_if.sv
// Configuration write channel of the I2C target register block.
interface i2crf_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/i2crf_ram.sv
// Generic single write port, single read port RAM with registered read data.
module i2crf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 46
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/i2crf_ctrl.sv
// Controller state machine of the I2C target register block.
module i2crf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  i2crf_pkg::t_dp_stat  i_stat,
    output i2crf_pkg::t_ctrl_cmd o_cmd
);

    i2crf_pkg::t_state r_state;
    i2crf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2crf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            i2crf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = i2crf_pkg::ST_EXEC;
                end
            end
            i2crf_pkg::ST_EXEC: begin
                // A waiting status dump starts the byte loop; everything else
                // executes once the output register can take its result.
                if (i_stat.take_full) begin
                    o_cmd.take_start = 1'b1;
                    n_state          = i2crf_pkg::ST_TAKE_READ;
                end else if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i2crf_pkg::ST_IDLE;
                end
            end
            i2crf_pkg::ST_TAKE_READ: begin
                o_cmd.take_read = 1'b1;
                n_state         = i2crf_pkg::ST_TAKE_LOAD;
            end
            i2crf_pkg::ST_TAKE_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.take_load = 1'b1;
                    n_state = i_stat.take_last ? i2crf_pkg::ST_IDLE
                                               : i2crf_pkg::ST_TAKE_READ;
                end
            end
            default: begin
                n_state = i2crf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/i2crf_dp.sv
// Datapath of the I2C target register block: register map, stores and output register.
module i2crf_dp #(
    parameter int EVENT_BYTES  = 12,
    parameter int STATUS_BYTES = 46,
    parameter int NAME_BYTES   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2crf_pkg::t_ctrl_cmd i_cmd,
    output i2crf_pkg::t_dp_stat  o_stat,
    input  logic [2:0]           i_in_command,
    input  logic [7:0]           i_in_data,
    input  logic [5:0]           i_in_index,
    input  logic [7:0]           i_in_source_addr,
    input  logic                 i_cfg_valid,
    input  logic [2:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_out_kind,
    output logic [7:0]           o_out_data,
    output logic                 o_out_last
);

    localparam int EW = (EVENT_BYTES > 1) ? $clog2(EVENT_BYTES) : 1;
    localparam int NW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int SW = (STATUS_BYTES > 1) ? $clog2(STATUS_BYTES) : 1;
    localparam logic [6:0] EVENT_LIM  = 7'(EVENT_BYTES);
    localparam logic [6:0] NAME_LIM   = 7'(NAME_BYTES);
    localparam logic [6:0] STATUS_LIM = 7'(STATUS_BYTES);
    localparam logic [5:0] STATUS_END = 6'(STATUS_BYTES - 1);

    // Configuration registers.
    logic [3:0] r_version;
    logic [7:0] r_filter_base;
    logic [7:0] r_code_status;
    logic [7:0] r_code_devcnt;
    logic [7:0] r_code_event;
    logic [7:0] r_code_name;
    logic [7:0] r_code_swrite;

    // Captured input item.
    logic [2:0] r_cmd;
    logic [7:0] r_data;
    logic [5:0] r_index;
    logic [7:0] r_src;

    // Block state.
    logic [7:0] r_reg_code;
    logic       r_code_latched;
    logic [5:0] r_read_offset;
    logic [7:0] r_live   [EVENT_BYTES];
    logic [7:0] r_staged [EVENT_BYTES];
    logic       r_data_ready;
    logic       r_device_count;
    logic [7:0] r_name   [NAME_BYTES];
    logic [5:0] r_write_offset;
    logic       r_status_received;
    logic [5:0] r_take_cnt;

    // Output register.
    logic       r_out_valid;
    logic [1:0] r_out_kind;
    logic [7:0] r_out_data;
    logic       r_out_last;

    logic [7:0] n_read_byte;
    logic       read_adv;
    logic       in_window;
    logic       buf_room;
    logic       ram_we;
    logic [7:0] ram_rd_data;

    always_comb begin
        n_read_byte = i2crf_pkg::BYTE_ZERO;
        read_adv    = 1'b0;
        if (r_reg_code == r_code_status) begin
            n_read_byte = {r_version, 3'b000, r_data_ready};
        end else if (r_reg_code == r_code_devcnt) begin
            n_read_byte = {7'd0, r_device_count};
        end else if (r_reg_code == r_code_event) begin
            if ({1'b0, r_read_offset} < EVENT_LIM) begin
                n_read_byte = r_live[r_read_offset[EW-1:0]];
                read_adv    = 1'b1;
            end
        end else if (r_reg_code == r_code_name) begin
            if ({1'b0, r_read_offset} < NAME_LIM) begin
                n_read_byte = r_name[r_read_offset[NW-1:0]];
                read_adv    = 1'b1;
            end
        end else begin
            n_read_byte = i2crf_pkg::BYTE_UNKNOWN;
        end
    end

    assign in_window = ({1'b0, r_src} >= {1'b0, r_filter_base}) &&
                       ({1'b0, r_src} < ({1'b0, r_filter_base} + i2crf_pkg::FILTER_SPAN));
    assign buf_room  = {1'b0, r_write_offset} < STATUS_LIM;
    assign ram_we    = i_cmd.exec && (r_cmd == i2crf_pkg::CMD_BUS_WRITE) && r_code_latched &&
                       (r_reg_code == r_code_swrite) && buf_room;

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.take_full = (r_cmd == i2crf_pkg::CMD_TAKE) && r_status_received;
    assign o_stat.take_last = r_take_cnt == STATUS_END;

    i2crf_ram #(
        .WIDTH (8),
        .DEPTH (STATUS_BYTES)
    ) u_status_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_write_offset[SW-1:0]),
        .i_wr_data (r_data),
        .i_rd_en   (i_cmd.take_read),
        .i_rd_addr (r_take_cnt[SW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // Configuration and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version         <= i2crf_pkg::RST_VERSION;
            r_filter_base     <= i2crf_pkg::RST_FILTER_BASE;
            r_code_status     <= i2crf_pkg::RST_CODE_STATUS;
            r_code_devcnt     <= i2crf_pkg::RST_CODE_DEVCNT;
            r_code_event      <= i2crf_pkg::RST_CODE_EVENT;
            r_code_name       <= i2crf_pkg::RST_CODE_NAME;
            r_code_swrite     <= i2crf_pkg::RST_CODE_SWRITE;
            r_reg_code        <= '0;
            r_code_latched    <= 1'b0;
            r_read_offset     <= '0;
            r_data_ready      <= 1'b0;
            r_device_count    <= 1'b0;
            r_write_offset    <= '0;
            r_status_received <= 1'b0;
            r_take_cnt        <= '0;
            r_out_valid       <= 1'b0;
            for (int i = 0; i < EVENT_BYTES; i++) begin
                r_live[i]   <= '0;
                r_staged[i] <= '0;
            end
            for (int i = 0; i < NAME_BYTES; i++) begin
                r_name[i] <= (i + 1 < NAME_BYTES) ? i2crf_pkg::default_name_byte(6'(i))
                                                  : i2crf_pkg::BYTE_ZERO;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    i2crf_pkg::REG_VERSION:     r_version     <= i_cfg_data[3:0];
                    i2crf_pkg::REG_FILTER_BASE: r_filter_base <= i_cfg_data;
                    i2crf_pkg::REG_CODE_STATUS: r_code_status <= i_cfg_data;
                    i2crf_pkg::REG_CODE_DEVCNT: r_code_devcnt <= i_cfg_data;
                    i2crf_pkg::REG_CODE_EVENT:  r_code_event  <= i_cfg_data;
                    i2crf_pkg::REG_CODE_NAME:   r_code_name   <= i_cfg_data;
                    i2crf_pkg::REG_CODE_SWRITE: r_code_swrite <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (i_cmd.exec) begin
                case (r_cmd)
                    i2crf_pkg::CMD_BUS_WRITE: begin
                        if (!r_code_latched) begin
                            r_reg_code     <= r_data;
                            r_read_offset  <= '0;
                            r_code_latched <= 1'b1;
                        end else if (ram_we) begin
                            r_write_offset <= r_write_offset + 6'd1;
                        end
                    end
                    i2crf_pkg::CMD_BUS_READ: begin
                        if (read_adv) begin
                            r_read_offset <= r_read_offset + 6'd1;
                        end
                    end
                    i2crf_pkg::CMD_BUS_STOP: begin
                        if ((r_reg_code == r_code_swrite) &&
                            ({1'b0, r_write_offset} == STATUS_LIM)) begin
                            r_status_received <= 1'b1;
                        end
                        r_code_latched <= 1'b0;
                    end
                    i2crf_pkg::CMD_STAGE: begin
                        if ({1'b0, r_index} < EVENT_LIM) begin
                            r_staged[r_index[EW-1:0]] <= r_data;
                        end
                    end
                    i2crf_pkg::CMD_COMMIT: begin
                        if (!in_window) begin
                            for (int i = 0; i < EVENT_BYTES; i++) begin
                                r_live[i] <= r_staged[i];
                            end
                            r_data_ready   <= 1'b1;
                            r_device_count <= 1'b1;
                        end
                    end
                    i2crf_pkg::CMD_NAME: begin
                        if (({1'b0, r_index} + 7'd1) < NAME_LIM) begin
                            r_name[r_index[NW-1:0]] <= r_data;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.take_start) begin
                r_status_received <= 1'b0;
                r_take_cnt        <= '0;
            end else if (i_cmd.take_load) begin
                r_take_cnt <= r_take_cnt + 6'd1;
            end

            if (i_cmd.exec || i_cmd.take_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd   <= i_in_command;
            r_data  <= i_in_data;
            r_index <= i_in_index;
            r_src   <= i_in_source_addr;
        end
        if (i_cmd.take_load) begin
            r_out_kind <= i2crf_pkg::KIND_STATUS;
            r_out_data <= ram_rd_data;
            r_out_last <= o_stat.take_last;
        end else if (i_cmd.exec) begin
            r_out_last <= 1'b1;
            case (r_cmd)
                i2crf_pkg::CMD_BUS_READ: begin
                    r_out_kind <= i2crf_pkg::KIND_READ;
                    r_out_data <= n_read_byte;
                end
                i2crf_pkg::CMD_TAKE: begin
                    r_out_kind <= i2crf_pkg::KIND_NONE;
                    r_out_data <= i2crf_pkg::BYTE_ZERO;
                end
                default: begin
                    r_out_kind <= i2crf_pkg::KIND_ACK;
                    r_out_data <= i2crf_pkg::BYTE_ZERO;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

// File: hdl/i2c_target_register_file.sv
// Top level of the I2C target register block: controller, datapath and channel ports.
//
// The block sits behind an I2C target shift engine on one side and local firmware
// logic on the other. Both feed one command channel (i_in): bus write byte, bus
// read, bus stop, stage event byte, commit event, name byte and take status.
// Every accepted transfer produces results on o_out; each result carries a kind,
// a byte and a last flag that marks the final result of that command.
// Configuration registers are written over i_cfg, which is always ready; writes
// are expected only while the block is idle.
//
// Command flow: a command is captured in ST_IDLE and executed in ST_EXEC once the
// output register is free. A take status with a packet waiting instead streams
// STATUS_BYTES results; for each byte, ST_TAKE_READ does the registered read of the
// status buffer RAM and ST_TAKE_LOAD loads the output register.
// The block accepts a new command while the previous result still sits in the
// output register; if the receiver stalls, execution waits until that register
// frees up, and the held result stays stable.
// Reset clears the code registers to their defaults, the event stores to zero,
// the name store to its default text and all control state; the status buffer
// needs no clearing, since it is only read after a full packet was written.
module i2c_target_register_file #(
    parameter int EVENT_BYTES  = 12,
    parameter int STATUS_BYTES = 46,
    parameter int NAME_BYTES   = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2crf_in_if.sink     i_in,
    i2crf_out_if.source  o_out,
    i2crf_cfg_if.sink    i_cfg
);

    i2crf_pkg::t_ctrl_cmd ctrl_cmd;
    i2crf_pkg::t_dp_stat  dp_stat;

    // Configuration writes are plain register loads.
    assign i_cfg.ready = 1'b1;

    i2crf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (dp_stat),
        .o_cmd      (ctrl_cmd)
    );

    i2crf_dp #(
        .EVENT_BYTES  (EVENT_BYTES),
        .STATUS_BYTES (STATUS_BYTES),
        .NAME_BYTES   (NAME_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (ctrl_cmd),
        .o_stat           (dp_stat),
        .i_in_command     (i_in.command),
        .i_in_data        (i_in.data),
        .i_in_index       (i_in.index),
        .i_in_source_addr (i_in.source_addr),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_out_kind       (o_out.kind),
        .o_out_data       (o_out.out_data),
        .o_out_last       (o_out.last)
    );

endmodule

// File: hdl/i2crf_checker.sv
// Port-level assertions for the I2C target register block, bound to its top level.
module i2crf_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    i2crf_in_if.sink    i_in,
    i2crf_out_if.source o_out
);

    // The result register is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    // A command is executed before the next one is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("command accepted while the previous one executes");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.kind) &&
        $stable(o_out.out_data) && $stable(o_out.last)))
        else $error("stalled result changed");

    // Acknowledges and empty status answers carry a zero byte and end their command.
    a_empty_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == i2crf_pkg::KIND_ACK ||
        o_out.kind == i2crf_pkg::KIND_NONE)) |-> (o_out.out_data == 8'h00 && o_out.last))
        else $error("acknowledge with data or without last");

    // A bus read answers with exactly one byte.
    a_read_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == i2crf_pkg::KIND_READ) |-> o_out.last)
        else $error("bus read result without last");

endmodule

bind i2c_target_register_file i2crf_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);

// File: tb/i2c_target_register_file_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the I2C target register block with a directed table and random traffic.
module i2c_target_register_file_tb;
    import i2crf_pkg::*;

    localparam int EVENT_BYTES  = 12;
    localparam int STATUS_BYTES = 46;
    localparam int NAME_BYTES   = 32;

    // The limit allows several times the slowest correct run, in which every command streams
    // a full packet while the receiver stalls the longest gap on every byte.
    localparam int CYCLE_LIMIT   = 1500000;
    // Settle time for one take, which streams STATUS_BYTES results, plus some margin.
    localparam int SETTLE_CYCLES = 2 * STATUS_BYTES + 20;
    // The receiver holds off once, for this many cycles, after this many commands were sent.
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 200;
    localparam int MAX_REPORTS   = 10;

    // Command 7 is not decoded by the block; it is answered with a plain acknowledge.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_data;
        logic       last;
    } t_response;

    // One row of the directed table. Where typed is set, the single result of the row is
    // given by hand; all other rows are checked against the register map model below.
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data;
        logic [5:0] index;
        logic [7:0] source_addr;
        logic       typed;
        logic [1:0] kind;
        logic [7:0] rd_byte;
    } t_row;

    localparam int DIRECTED_COUNT = 26;

    // Reset configuration throughout: status code 0, device count 1, event 2, name 3,
    // status write 4, filter window 0xE0 .. 0xEF, version 1.
    localparam t_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Status byte straight after reset: version 1, no data ready yet.
        '{CMD_BUS_READ,  8'hFF, 6'd63, 8'hFF, 1'b1, KIND_READ, 8'h10},
        // Nothing has been received, so a take reports that no status is waiting.
        '{CMD_TAKE,      8'h00, 6'd0,  8'h00, 1'b1, KIND_NONE, BYTE_ZERO},
        '{CMD_BUS_WRITE, 8'h01, 6'd0,  8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        '{CMD_BUS_READ,  8'h00, 6'd0,  8'h00, 1'b1, KIND_READ, 8'h00},
        '{CMD_BUS_STOP,  8'h00, 6'd0,  8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        // Stage the first and last event byte, and one index just past the end.
        '{CMD_STAGE,     8'hFF, 6'd0,  8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        '{CMD_STAGE,     8'hA5, 6'd11, 8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        '{CMD_STAGE,     8'h5A, 6'd12, 8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        // Both ends of the filter window are ignored; the address just above it commits.
        '{CMD_COMMIT,    8'h00, 6'd0,  8'hE0, 1'b1, KIND_ACK,  BYTE_ZERO},
        '{CMD_COMMIT,    8'h00, 6'd0,  8'hEF, 1'b1, KIND_ACK,  BYTE_ZERO},
        '{CMD_COMMIT,    8'h00, 6'd0,  8'hF0, 1'b1, KIND_ACK,  BYTE_ZERO},
        '{CMD_BUS_WRITE, 8'h02, 6'd0,  8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        '{CMD_BUS_READ,  8'h00, 6'd0,  8'h00, 1'b1, KIND_READ, 8'hFF},
        '{CMD_BUS_READ,  8'h00, 6'd0,  8'h00, 1'b0, KIND_ACK,  BYTE_ZERO},
        '{CMD_BUS_STOP,  8'h00, 6'd0,  8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        // The last name byte is the terminator and cannot be written.
        '{CMD_NAME,      8'hFF, 6'd31, 8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        '{CMD_NAME,      8'h7E, 6'd30, 8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        '{CMD_BUS_WRITE, 8'h03, 6'd0,  8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        '{CMD_BUS_READ,  8'h00, 6'd0,  8'h00, 1'b1, KIND_READ, 8'h49},
        '{CMD_BUS_STOP,  8'h00, 6'd0,  8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        // An unknown register code reads as 0xFF.
        '{CMD_BUS_WRITE, 8'hFF, 6'd0,  8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        '{CMD_BUS_READ,  8'h00, 6'd0,  8'h00, 1'b1, KIND_READ, BYTE_UNKNOWN},
        '{CMD_UNUSED,    8'hFF, 6'd63, 8'hFF, 1'b1, KIND_ACK,  BYTE_ZERO},
        '{CMD_BUS_STOP,  8'h00, 6'd0,  8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        // With an event committed, the status byte now shows data ready.
        '{CMD_BUS_WRITE, 8'h00, 6'd0,  8'h00, 1'b1, KIND_ACK,  BYTE_ZERO},
        '{CMD_BUS_READ,  8'h00, 6'd0,  8'h00, 1'b1, KIND_READ, 8'h11}
    };

    logic i_clk;
    logic i_rst_n;

    i2crf_in_if  in_ch ();
    i2crf_out_if out_ch ();
    i2crf_cfg_if cfg_ch ();

    i2c_target_register_file #(
        .EVENT_BYTES  (EVENT_BYTES),
        .STATUS_BYTES (STATUS_BYTES),
        .NAME_BYTES   (NAME_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Configuration as the register map sees it.
    logic [3:0] cur_version;
    logic [7:0] cur_filter_base;
    logic [7:0] cur_code_status;
    logic [7:0] cur_code_devcnt;
    logic [7:0] cur_code_event;
    logic [7:0] cur_code_name;
    logic [7:0] cur_code_swrite;

    // Internal state of the register map.
    logic [7:0] bus_code;
    logic       code_held;
    logic [5:0] rd_pos;
    logic [7:0] event_live   [EVENT_BYTES];
    logic [7:0] event_staged [EVENT_BYTES];
    logic       ready_flag;
    logic       device_present;
    logic [7:0] name_bytes   [NAME_BYTES];
    logic [7:0] packet_bytes [STATUS_BYTES];
    logic [5:0] wr_pos;
    logic       packet_flagged;

    // Results the block owes, oldest first.
    t_response pending_responses [$];

    int  fail_count  = 0;
    int  items_sent  = 0;
    // Both sides stop idling while this is set.
    bit  steady_flow = 1'b0;
    // Set while random traffic runs, so that the long receiver hold-off meets a busy sender.
    bit  traffic_on  = 1'b0;

    function automatic void reset_register_map();
        string txt;
        txt = "I2C Target";
        cur_version     = RST_VERSION;
        cur_filter_base = RST_FILTER_BASE;
        cur_code_status = RST_CODE_STATUS;
        cur_code_devcnt = RST_CODE_DEVCNT;
        cur_code_event  = RST_CODE_EVENT;
        cur_code_name   = RST_CODE_NAME;
        cur_code_swrite = RST_CODE_SWRITE;
        bus_code        = 8'h00;
        code_held       = 1'b0;
        rd_pos          = '0;
        ready_flag      = 1'b0;
        device_present  = 1'b0;
        wr_pos          = '0;
        packet_flagged  = 1'b0;
        for (int i = 0; i < EVENT_BYTES; i++) begin
            event_live[i]   = 8'h00;
            event_staged[i] = 8'h00;
        end
        for (int i = 0; i < NAME_BYTES; i++) begin
            name_bytes[i] = (i < txt.len() && i + 1 < NAME_BYTES) ? txt[i] : 8'h00;
        end
        // Never read before it is fully written; held at zero only to stay defined.
        for (int i = 0; i < STATUS_BYTES; i++) begin
            packet_bytes[i] = 8'h00;
        end
    endfunction

    // Byte served to a bus read; event and name reads advance the read position.
    function automatic logic [7:0] serve_bus_read();
        logic [7:0] b;
        b = BYTE_ZERO;
        if (bus_code == cur_code_status) begin
            b = {cur_version, 3'b000, ready_flag};
        end else if (bus_code == cur_code_devcnt) begin
            b = {7'd0, device_present};
        end else if (bus_code == cur_code_event) begin
            if (rd_pos < EVENT_BYTES) begin
                b = event_live[rd_pos];
                rd_pos = rd_pos + 6'd1;
            end
        end else if (bus_code == cur_code_name) begin
            if (rd_pos < NAME_BYTES) begin
                b = name_bytes[rd_pos];
                rd_pos = rd_pos + 6'd1;
            end
        end else begin
            b = BYTE_UNKNOWN;
        end
        return b;
    endfunction

    // Advances the register map by one command and queues the results it owes.
    function automatic void apply_command(input logic [2:0] cmd, input logic [7:0] data,
                                          input logic [5:0] idx, input logic [7:0] src);
        t_response  r;
        logic [8:0] lo;
        r.kind     = KIND_ACK;
        r.out_data = BYTE_ZERO;
        r.last     = 1'b1;
        lo         = {1'b0, cur_filter_base};
        case (cmd)
            CMD_BUS_WRITE: begin
                if (!code_held) begin
                    bus_code  = data;
                    rd_pos    = '0;
                    code_held = 1'b1;
                end else if (bus_code == cur_code_swrite && wr_pos < STATUS_BYTES) begin
                    packet_bytes[wr_pos] = data;
                    wr_pos = wr_pos + 6'd1;
                end
            end
            CMD_BUS_READ: begin
                r.kind     = KIND_READ;
                r.out_data = serve_bus_read();
            end
            CMD_BUS_STOP: begin
                if (bus_code == cur_code_swrite && wr_pos == STATUS_BYTES) begin
                    packet_flagged = 1'b1;
                end
                code_held = 1'b0;
            end
            CMD_STAGE: begin
                if (idx < EVENT_BYTES) event_staged[idx] = data;
            end
            CMD_COMMIT: begin
                // The window does not wrap past 255.
                if (!({1'b0, src} >= lo && {1'b0, src} < lo + FILTER_SPAN)) begin
                    for (int i = 0; i < EVENT_BYTES; i++) event_live[i] = event_staged[i];
                    ready_flag     = 1'b1;
                    device_present = 1'b1;
                end
            end
            CMD_NAME: begin
                if (idx + 1 < NAME_BYTES) name_bytes[idx] = data;
            end
            CMD_TAKE: begin
                if (!packet_flagged) begin
                    r.kind = KIND_NONE;
                end else begin
                    // All but the final byte go out here; the final one is queued below.
                    for (int k = 0; k < STATUS_BYTES - 1; k++) begin
                        r.kind     = KIND_STATUS;
                        r.out_data = packet_bytes[k];
                        r.last     = 1'b0;
                        pending_responses.push_back(r);
                    end
                    r.kind         = KIND_STATUS;
                    r.out_data     = packet_bytes[STATUS_BYTES - 1];
                    r.last         = 1'b1;
                    packet_flagged = 1'b0;
                end
            end
            default: begin
            end
        endcase
        pending_responses.push_back(r);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [5:0] rand_index();
        return 6'($urandom_range(0, 63));
    endfunction

    // Offers one command on the input channel and waits for its transfer. Entered and left
    // at a falling edge, so valid stays high across back-to-back commands.
    task automatic send_command(input logic [2:0] cmd, input logic [7:0] data,
                                input logic [5:0] idx, input logic [7:0] src,
                                input logic typed, input logic [1:0] kind,
                                input logic [7:0] rd_byte);
        int        gap;
        t_response r;
        gap = steady_flow ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.data        <= data;
        in_ch.index       <= idx;
        in_ch.source_addr <= src;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        apply_command(cmd, data, idx, src);
        if (typed) begin
            // A hand-typed row overrides what the model predicted for it.
            r = pending_responses.pop_back();
            r.kind     = kind;
            r.out_data = rd_byte;
            r.last     = 1'b1;
            pending_responses.push_back(r);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_plain(input logic [2:0] cmd, input logic [7:0] data,
                              input logic [5:0] idx, input logic [7:0] src);
        send_command(cmd, data, idx, src, 1'b0, KIND_ACK, BYTE_ZERO);
    endtask

    // Ends a bus transfer that noise may have left open, so the next write latches a code.
    task automatic close_open_transfer();
        if (code_held) send_plain(CMD_BUS_STOP, rand_byte(), rand_index(), rand_byte());
    endtask

    // Bus write of a status packet: mostly exactly full, sometimes short or overlong.
    task automatic send_status_packet();
        int len;
        close_open_transfer();
        send_plain(CMD_BUS_WRITE, cur_code_swrite, rand_index(), rand_byte());
        len = ($urandom_range(0, 2) == 0) ? $urandom_range(40, 50) : STATUS_BYTES;
        repeat (len) send_plain(CMD_BUS_WRITE, rand_byte(), rand_index(), rand_byte());
        send_plain(CMD_BUS_STOP, rand_byte(), rand_index(), rand_byte());
        if ($urandom_range(0, 3) != 0) send_plain(CMD_TAKE, rand_byte(), rand_index(), rand_byte());
    endtask

    // Bus read transfer: latch a code, then read a run of bytes, usually closed by a stop.
    task automatic send_read_transfer();
        logic [7:0] code;
        int         n;
        close_open_transfer();
        case ($urandom_range(0, 5))
            0: code = cur_code_status;
            1: code = cur_code_devcnt;
            2: code = cur_code_event;
            3: code = cur_code_name;
            4: code = cur_code_swrite;
            default: code = rand_byte();
        endcase
        send_plain(CMD_BUS_WRITE, code, rand_index(), rand_byte());
        // Long runs walk past the end of the event and name stores.
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 36) : $urandom_range(1, 6);
        repeat (n) send_plain(CMD_BUS_READ, rand_byte(), rand_index(), rand_byte());
        if ($urandom_range(0, 7) != 0) send_plain(CMD_BUS_STOP, rand_byte(), rand_index(),
                                                  rand_byte());
    endtask

    // A few local-side operations: staging, commits near the filter window, names, takes.
    task automatic send_local_ops();
        logic [5:0] idx;
        logic [7:0] src;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
                0: begin
                    idx = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, EVENT_BYTES - 1))
                                                      : rand_index();
                    send_plain(CMD_STAGE, rand_byte(), idx, rand_byte());
                end
                1: begin
                    src = ($urandom_range(0, 1) != 0)
                        ? 8'(cur_filter_base + 8'($urandom_range(0, 20)) - 8'd2) : rand_byte();
                    send_plain(CMD_COMMIT, rand_byte(), rand_index(), src);
                end
                2: begin
                    idx = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, NAME_BYTES - 1))
                                                      : rand_index();
                    send_plain(CMD_NAME, rand_byte(), idx, rand_byte());
                end
                default: send_plain(CMD_TAKE, rand_byte(), rand_index(), rand_byte());
            endcase
        end
    endtask

    task automatic run_traffic(input int target);
        int first;
        int pick;
        first      = items_sent;
        traffic_on = 1'b1;
        while (items_sent - first < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_status_packet();
            end else if (pick < 50) begin
                send_read_transfer();
            end else if (pick < 85) begin
                send_local_ops();
            end else begin
                // Noise: any command with any fields, the undecoded one included.
                send_plain(3'($urandom_range(0, 7)), rand_byte(), rand_index(), rand_byte());
            end
        end
        traffic_on = 1'b0;
    endtask

    // Stops offering commands and waits until every owed result has been seen.
    task automatic wait_drained(input int settle);
        in_ch.valid <= 1'b0;
        while (pending_responses.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // One register write over the configuration channel, entered and left at a falling edge.
    task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            REG_VERSION:     cur_version     = value[3:0];
            REG_FILTER_BASE: cur_filter_base = value;
            REG_CODE_STATUS: cur_code_status = value;
            REG_CODE_DEVCNT: cur_code_devcnt = value;
            REG_CODE_EVENT:  cur_code_event  = value;
            REG_CODE_NAME:   cur_code_name   = value;
            REG_CODE_SWRITE: cur_code_swrite = value;
            default: begin
            end
        endcase
        @(negedge i_clk);
    endtask

    task automatic write_all_registers(input logic [3:0] version, input logic [7:0] filter,
                                       input logic [7:0] cs, input logic [7:0] cd,
                                       input logic [7:0] ce, input logic [7:0] cn,
                                       input logic [7:0] cw);
        write_register(REG_VERSION, {4'd0, version});
        write_register(REG_FILTER_BASE, filter);
        write_register(REG_CODE_STATUS, cs);
        write_register(REG_CODE_DEVCNT, cd);
        write_register(REG_CODE_EVENT, ce);
        write_register(REG_CODE_NAME, cn);
        write_register(REG_CODE_SWRITE, cw);
        cfg_ch.valid <= 1'b0;
    endtask

    // Every result transfer is compared with the oldest owed result.
    always @(posedge i_clk) begin
        t_response e;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_responses.size() == 0) begin
                note_failure($sformatf("result with none owed: kind %0d data %02h last %0d",
                                       out_ch.kind, out_ch.out_data, out_ch.last));
            end else begin
                e = pending_responses.pop_front();
                if (out_ch.kind !== e.kind || out_ch.out_data !== e.out_data ||
                    out_ch.last !== e.last) begin
                    note_failure($sformatf({"result mismatch: expected kind %0d data %02h ",
                                            "last %0d, got kind %0d data %02h last %0d"},
                        e.kind, e.out_data, e.last, out_ch.kind, out_ch.out_data, out_ch.last));
                end
            end
        end
    end

    // Receiver: random stalls per result, and once a long hold-off that lets the block fill
    // up and push back on the sender.
    initial begin : result_receiver
        int stall;
        bit hold_done;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 9);
            if (!hold_done && traffic_on && items_sent >= HOLD_AFTER) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n === 1'b1 && out_ch.valid === 1'b1));
            @(negedge i_clk);
        end
    end

    // A hung handshake ends the run here.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] base;
        t_row       row;

        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.command     = CMD_BUS_WRITE;
        in_ch.data        = 8'h00;
        in_ch.index       = 6'd0;
        in_ch.source_addr = 8'h00;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_VERSION;
        cfg_ch.data       = 8'h00;
        reset_register_map();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with the reset configuration.
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            row = DIRECTED_ROWS[i];
            send_command(row.command, row.data, row.index, row.source_addr,
                         row.typed, row.kind, row.rd_byte);
        end

        // Reset configuration; the first full packet is written right away so that
        // takes with a status waiting occur from the start.
        send_status_packet();
        run_traffic(80);

        // All codes collide at zero and the window starts at address zero.
        wait_drained(8);
        write_all_registers(4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        run_traffic(60);

        // All codes collide at 255; only address 255 is filtered. Neither side idles here.
        wait_drained(8);
        write_all_registers(4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        steady_flow = 1'b1;
        run_traffic(60);
        wait_drained(8);
        steady_flow = 1'b0;

        // Distinct codes in shuffled order, window at the top of the address range.
        base = 8'($urandom_range(0, 250));
        write_all_registers(4'($urandom_range(0, 15)), 8'hF0, base + 8'd2, base,
                            base + 8'd4, base + 8'd1, base + 8'd3);
        send_status_packet();
        run_traffic(60);

        // Fully random configuration.
        wait_drained(8);
        write_all_registers(4'($urandom_range(0, 15)), rand_byte(), rand_byte(), rand_byte(),
                            rand_byte(), rand_byte(), rand_byte());
        run_traffic(80);

        wait_drained(SETTLE_CYCLES);
        if (fail_count == 0 && pending_responses.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
